/* rtl/utf8_byte_stream_decoder_assert.svh */
// assertion macros for the utf8 byte stream decoder
// they expect clk and rst_n in scope
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

`define U8D_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/u8d_pkg.sv */
package u8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CODE_W = 16;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;
    localparam logic [BYTE_W-1:0] TWO_MASK  = 8'h1F;
    localparam logic [BYTE_W-1:0] THREE_MASK = 8'h0F;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    // kind of sequence in progress
    typedef enum logic [3:0] {
        KIND_NONE  = 4'b0001,
        KIND_TWO   = 4'b0010,
        KIND_THREE = 4'b0100,
        KIND_BAD   = 4'b1000
    } kind_t;

    typedef struct packed {
        logic [1:0]        pending;
        kind_t             kind;
        logic [CODE_W-1:0] partial;
    } dec_state_t;

    localparam dec_state_t STATE_IDLE = '{
        pending: PEND_NONE,
        kind:    KIND_NONE,
        partial: '0
    };

endpackage

/* rtl/utf8_byte_stream_decoder.sv */
// channel | direction | handshake           | payload
// in      | receive   | in_valid, in_stall   | in_byte
// out     | send      | out_valid, out_stall | code_point
//
// one byte per cycle when out is not stalled; a result is presented once the byte
// that completes its sequence is accepted and has passed the input register, then
// the result register
// rst_n clears the decode state and both valid flags; anything in flight is dropped
// a stalled result holds the input register, which then stalls in; bytes that
// give no result still pass while a result waits
module utf8_byte_stream_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [u8d_pkg::BYTE_W-1:0]  in_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [u8d_pkg::CODE_W-1:0]  code_point
);
    import u8d_pkg::*;

    `include "utf8_byte_stream_decoder_assert.svh"

    logic              byte_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    logic              out_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic              step_emit;
    logic [CODE_W-1:0] step_code;
    logic              advance;
    logic              out_free;

    u8d_step u_step (
        .cur        (state_reg),
        .in_byte    (byte_reg),
        .nxt        (state_next),
        .emit       (step_emit),
        .code_point (step_code)
    );

    assign out_free = !out_valid_reg || !out_stall;
    // a byte with no result may move on even while a result waits
    assign advance  = byte_valid_reg && (out_free || !step_emit);
    assign in_stall = byte_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            state_reg      <= STATE_IDLE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                byte_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && step_emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= in_byte;
        end
        if (out_free && advance && step_emit)
        begin
            code_reg <= step_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_reg;

    `U8D_ASSERT_ALWAYS(a_pending_range, state_reg.pending != 2'd3, "pending count of three")
    `U8D_ASSERT_ALWAYS(a_kind_idle, (state_reg.kind == KIND_NONE) == (state_reg.pending == PEND_NONE), "kind and pending disagree")
    `U8D_ASSERT_ALWAYS(a_two_left, (state_reg.pending != PEND_TWO) || (state_reg.kind == KIND_THREE), "two bytes pending outside a three byte sequence")
    `U8D_ASSERT_NEXT(a_emit_lands, advance && step_emit, out_valid_reg, "completed transaction not presented")
    `U8D_ASSERT_NEXT(a_bad_zero, advance && step_emit && (state_reg.kind == KIND_BAD), code_reg == '0, "unsupported lead gave a nonzero code")

endmodule

/* rtl/u8d_step.sv */
module u8d_step (
    input  u8d_pkg::dec_state_t         cur,
    input  logic [u8d_pkg::BYTE_W-1:0]  in_byte,
    output u8d_pkg::dec_state_t         nxt,
    output logic                        emit,
    output logic [u8d_pkg::CODE_W-1:0]  code_point
);
    import u8d_pkg::*;

    logic [CODE_W-1:0] low6;
    logic [CODE_W-1:0] lead2;
    logic [CODE_W-1:0] lead3;

    assign low6  = {{(CODE_W-BYTE_W){1'b0}}, in_byte & CONT_MASK};
    assign lead2 = {{(CODE_W-BYTE_W){1'b0}}, in_byte & TWO_MASK} << 6;
    assign lead3 = {{(CODE_W-BYTE_W){1'b0}}, in_byte & THREE_MASK} << 12;

    always_comb
    begin
        nxt        = STATE_IDLE;
        emit       = 1'b0;
        code_point = '0;
        case (cur.pending)
            PEND_ONE:
            begin
                // last byte of the sequence
                emit = 1'b1;
                if (cur.kind != KIND_BAD)
                begin
                    code_point = cur.partial | low6;
                end
            end
            PEND_TWO:
            begin
                nxt.pending = PEND_ONE;
                nxt.kind    = cur.kind;
                nxt.partial = cur.partial | (low6 << 6);
            end
            default:
            begin
                // idle, and the unreachable pending count of three
                if (!in_byte[BYTE_W-1])
                begin
                    emit       = 1'b1;
                    code_point = {{(CODE_W-BYTE_W){1'b0}}, in_byte};
                end
                else if (in_byte inside {[8'hC0:8'hDF]})
                begin
                    nxt.pending = PEND_ONE;
                    nxt.kind    = KIND_TWO;
                    nxt.partial = lead2;
                end
                else if (in_byte inside {[8'hE0:8'hEF]})
                begin
                    nxt.pending = PEND_TWO;
                    nxt.kind    = KIND_THREE;
                    nxt.partial = lead3;
                end
                else
                begin
                    // unsupported lead swallows one byte then gives zero
                    nxt.pending = PEND_ONE;
                    nxt.kind    = KIND_BAD;
                end
            end
        endcase
    end

endmodule

/* sim/utf8_decode_checker.sv */
module utf8_decode_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [u8d_pkg::BYTE_W-1:0] in_byte,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [u8d_pkg::CODE_W-1:0] code_point,
    output int unsigned                fail_count,
    output int unsigned                codes_waiting,
    output int unsigned                bytes_seen,
    output int unsigned                codes_seen,
    output int unsigned                bad_leads_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    logic [1:0]        seq_pending;
    kind_t             seq_kind;
    logic [CODE_W-1:0] seq_partial;
    logic [CODE_W-1:0] expected_codes[$];

    function automatic void clear_sequence();
        seq_pending = PEND_NONE;
        seq_kind    = KIND_NONE;
        seq_partial = '0;
    endfunction

    // returns 1 when the byte completes a character, with its value in cp
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b,
                                       output logic [CODE_W-1:0] cp);
        cp = '0;
        case (seq_pending)
            PEND_TWO:
            begin
                seq_partial = seq_partial | (CODE_W'(b & CONT_MASK) << 6);
                seq_pending = PEND_ONE;
                return 1'b0;
            end
            PEND_ONE:
            begin
                if (seq_kind == KIND_BAD)
                    bad_leads_seen++;
                else
                    cp = seq_partial | CODE_W'(b & CONT_MASK);
                clear_sequence();
                return 1'b1;
            end
            default:
            begin
                // idle, and the unreachable pending count is treated as idle
                clear_sequence();
                if (!b[7])
                begin
                    cp = CODE_W'(b);
                    return 1'b1;
                end
                if (b[7:5] == 3'b110)
                begin
                    seq_partial = CODE_W'(b & TWO_MASK) << 6;
                    seq_kind    = KIND_TWO;
                    seq_pending = PEND_ONE;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    seq_partial = CODE_W'(b & THREE_MASK) << 12;
                    seq_kind    = KIND_THREE;
                    seq_pending = PEND_TWO;
                end
                else
                begin
                    // stray continuation or a lead from 0xF0 up: eat one byte, give zero
                    seq_kind    = KIND_BAD;
                    seq_pending = PEND_ONE;
                end
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [CODE_W-1:0] want;
        logic [CODE_W-1:0] cp;
        if (!rst_n)
        begin
            clear_sequence();
            expected_codes.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                codes_seen++;
                if (expected_codes.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: code_point %h arrived with nothing expected",
                             $time, code_point);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (code_point !== want)
                    begin
                        fail_count++;
                        $display("%0t: code_point mismatch, expected %h, got %h",
                                 $time, want, code_point);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                bytes_seen++;
                if (decode_byte(in_byte, cp))
                    expected_codes.push_back(cp);
            end
        end
        codes_waiting = expected_codes.size();
    end

endmodule

/* sim/utf8_byte_stream_decoder_tb.sv */
module utf8_byte_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [BYTE_W-1:0] in_byte   = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [CODE_W-1:0] code_point;

    int unsigned fail_count;
    int unsigned codes_waiting;
    int unsigned bytes_seen;
    int unsigned codes_seen;
    int unsigned bad_leads_seen;

    logic [BYTE_W-1:0] byte_stream[$];

    utf8_byte_stream_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point)
    );

    utf8_decode_checker watch_u8d (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code_point     (code_point),
        .fail_count     (fail_count),
        .codes_waiting  (codes_waiting),
        .bytes_seen     (bytes_seen),
        .codes_seen     (codes_seen),
        .bad_leads_seen (bad_leads_seen)
    );

    always #1 clk = ~clk;

    function automatic logic [BYTE_W-1:0] rand_cont();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [BYTE_W-1:0] rand_bad_lead();
        if ($urandom_range(0, 1) == 1)
            return {2'b10, 6'($urandom)};
        return {4'b1111, 4'($urandom)};
    endfunction

    task automatic build_stream();
        int pick;
        // corners: ascii ends, shortest and longest two and three byte forms
        byte_stream = '{8'h00, 8'h7F,
                        8'hC0, 8'h80, 8'hDF, 8'hBF,
                        8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                        // unsupported leads, each followed by any byte
                        8'h80, 8'h41, 8'hFF, 8'hFF, 8'hF0, 8'hC3,
                        // continuation bytes taken without checking
                        8'hC3, 8'h41, 8'hE1, 8'hE2, 8'hC5};
        while (byte_stream.size() < 1570)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                byte_stream.push_back(BYTE_W'($urandom_range(0, 127)));
            else if (pick < 50)
            begin
                byte_stream.push_back({3'b110, 5'($urandom)});
                byte_stream.push_back(rand_cont());
            end
            else if (pick < 75)
            begin
                byte_stream.push_back({4'b1110, 4'($urandom)});
                byte_stream.push_back(rand_cont());
                byte_stream.push_back(rand_cont());
            end
            else if (pick < 85)
            begin
                byte_stream.push_back(rand_bad_lead());
                byte_stream.push_back(BYTE_W'($urandom));
            end
            else if (pick < 95)
            begin
                // valid lead, then continuations of any value
                if ($urandom_range(0, 1) == 1)
                    byte_stream.push_back({3'b110, 5'($urandom)});
                else
                begin
                    byte_stream.push_back({4'b1110, 4'($urandom)});
                    byte_stream.push_back(BYTE_W'($urandom));
                end
                byte_stream.push_back(BYTE_W'($urandom));
            end
            else
                byte_stream.push_back(BYTE_W'($urandom));
        end
    endtask

    // receiver back-pressure, switching pattern every so often
    initial
    begin : stall_gen
        stall_mode_t mode;
        int unsigned span;
        int unsigned tick;
        tick = 0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_COIN:     out_stall <= ($urandom_range(0, 1) == 1);
                    STALL_PERIODIC: out_stall <= (tick % 4 == 3);
                    default:        out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int idx;
        int burst;
        int gap;
        build_stream();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idx = 0;
        while (idx < byte_stream.size())
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && idx < byte_stream.size())
            begin
                in_valid <= 1'b1;
                in_byte  <= byte_stream[idx];
                @(posedge clk);
                while (in_stall)
                    @(posedge clk);
                @(negedge clk);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b0;
        while (codes_waiting != 0)
            @(negedge clk);
        // a trailing incomplete sequence gives nothing, but let the pipe drain
        repeat (8) @(negedge clk);
        $display("%0d bytes decoded, %0d code points compared (%0d from unsupported leads)",
                 bytes_seen, codes_seen, bad_leads_seen);
        $display("traffic ran in bursts with gaps against shifting output back-pressure");
        if (fail_count == 0 && codes_waiting == 0)
            $display("utf8_byte_stream_decoder_tb OK");
        else
            $display("utf8_byte_stream_decoder_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d code points still expected", codes_waiting);
        $display("utf8_byte_stream_decoder_tb NOT OK");
        $finish;
    end

endmodule
